@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of the codebook dot-product block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define CLDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Assertion failed.");

// Next-cycle implication under an active-low reset.
`define CLDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Assertion failed.");

`endif

@@ sv/cldp_pkg.sv @@
// Shared types and constants of the codebook dot-product block.
package cldp_pkg;

	localparam logic [1:0] CMD_LUT  = 2'd0;
	localparam logic [1:0] CMD_BYTE = 2'd1;
	localparam logic [1:0] CMD_ACT  = 2'd2;

	localparam logic [1:0] CFG_INDEX_BITS = 2'd0;
	localparam logic [1:0] CFG_FORMAT     = 2'd1;
	localparam logic [1:0] CFG_ROW_LENGTH = 2'd2;

	localparam int CFG_W     = 13;
	localparam int WIDX_W    = 30;
	localparam int BITPOS_W  = 34;
	localparam int BYTEPOS_W = 31;
	localparam int PTR_W     = 32;
	localparam int EXP_W     = 11;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	typedef struct packed {
		logic               sign;
		logic               nan;
		logic               inf;
		logic [21:0]        sig;
		logic signed [7:0]  exp;
	} prod_t;

	typedef struct packed {
		logic load;
		logic addr;
		logic bitp;
		logic rd_issue;
		logic rd_take;
		logic lut;
		logic dec;
		logic norm;
		logic align;
		logic add;
		logic lzc;
		logic rnd;
		logic pack;
	} dp_cmd_t;

	typedef struct packed {
		logic in_act;
		logic last;
	} dp_stat_t;

	typedef struct packed {
		logic norm;
		logic align;
		logic add;
		logic lzc;
		logic rnd;
		logic pack;
		logic clear;
	} fma_cmd_t;

endpackage

@@ sv/cldp_fma.sv @@
// Multi-step single-precision fused multiply-add unit holding the accumulator.
module cldp_fma (
	input  logic                clk,
	input  logic                arst_n,
	input  cldp_pkg::fma_cmd_t  cmd,
	input  cldp_pkg::prod_t     prod,
	output logic [31:0]         res
);

	localparam int EW = cldp_pkg::EXP_W;
	localparam logic signed [EW-1:0] SUB_EXP  = -11'sd149;
	localparam logic signed [EW-1:0] BIAS     = 11'sd150;
	localparam logic signed [EW-1:0] LOW_LSB  = -11'sd122;
	localparam logic signed [EW-1:0] GUARD    = 11'sd27;
	localparam logic signed [EW-1:0] TOP_OFF  = 11'sd23;
	localparam logic signed [EW-1:0] EXP_MAX  = 11'sd255;

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		logic       found;
		begin
			n = 5'd0;
			found = 1'b0;
			for (int i = 23; i >= 0; i--) begin
				if (!found) begin
					if (v[i]) found = 1'b1;
					else n = n + 5'd1;
				end
			end
			return n;
		end
	endfunction

	function automatic logic [5:0] top52(input logic [51:0] v);
		logic [5:0] p;
		begin
			p = 6'd0;
			for (int i = 0; i < 52; i++) begin
				if (v[i]) p = 6'(i);
			end
			return p;
		end
	endfunction

	logic [31:0]           acc_q;
	logic                  spec_q;
	logic [31:0]           spec_val_q;
	logic                  np_sign_q, nc_sign_q, np_zero_q, nc_zero_q;
	logic [23:0]           np_sig_q, nc_sig_q;
	logic signed [EW-1:0]  np_exp_q, nc_exp_q;
	logic [50:0]           aw_q, bw_q;
	logic                  sub_q, sgn_q;
	logic signed [EW-1:0]  ea_q;
	logic [51:0]           s_q;
	logic signed [EW-1:0]  lsb_q;
	logic                  zero_q;
	logic [24:0]           q_q;
	logic signed [EW-1:0]  eq_q;

	// Operand normalisation and special values.
	logic [7:0]            c_e;
	logic [23:0]           c_sig, c_nsig, p_sig24, p_nsig;
	logic signed [EW-1:0]  c_exp, c_nexp, p_exp, p_nexp;
	logic [4:0]            c_lz, p_lz;
	logic                  c_nan, c_inf, c_zero, p_zero;
	logic                  n_spec;
	logic [31:0]           n_spec_val;

	always_comb begin
		c_e     = acc_q[30:23];
		c_nan   = (c_e == 8'hFF) && (acc_q[22:0] != 23'd0);
		c_inf   = (c_e == 8'hFF) && (acc_q[22:0] == 23'd0);
		c_zero  = (acc_q[30:0] == 31'd0);
		c_sig   = {(c_e != 8'd0), acc_q[22:0]};
		c_exp   = (c_e == 8'd0) ? SUB_EXP : ($signed({3'b000, c_e}) - BIAS);
		c_lz    = lzc24(c_sig);
		c_nsig  = c_sig << c_lz;
		c_nexp  = c_exp - $signed({6'd0, c_lz});
		p_zero  = !prod.nan && !prod.inf && (prod.sig == 22'd0);
		p_sig24 = {prod.sig, 2'b00};
		p_exp   = EW'(prod.exp) - 11'sd2;
		p_lz    = lzc24(p_sig24);
		p_nsig  = p_sig24 << p_lz;
		p_nexp  = p_exp - $signed({6'd0, p_lz});
		n_spec     = 1'b1;
		n_spec_val = cldp_pkg::CANON_NAN;
		if (prod.nan || c_nan || (prod.inf && c_inf && (prod.sign != acc_q[31]))) begin
			n_spec_val = cldp_pkg::CANON_NAN;
		end else if (prod.inf) begin
			n_spec_val = {prod.sign, 8'hFF, 23'd0};
		end else if (c_inf) begin
			n_spec_val = acc_q;
		end else if (p_zero && c_zero) begin
			n_spec_val = {prod.sign & acc_q[31], 31'd0};
		end else begin
			n_spec = 1'b0;
		end
	end

	// Alignment of the smaller operand below the larger one.
	logic                  a_is_p, a_sign, b_sign, b_zero;
	logic [23:0]           a_sig, b_sig;
	logic signed [EW-1:0]  a_exp, b_exp, dif;
	logic [50:0]           b_full, b_shift;
	logic                  b_sticky;

	always_comb begin
		a_is_p = !np_zero_q && (nc_zero_q || (np_exp_q > nc_exp_q) ||
			((np_exp_q == nc_exp_q) && (np_sig_q >= nc_sig_q)));
		a_sign = a_is_p ? np_sign_q : nc_sign_q;
		a_sig  = a_is_p ? np_sig_q  : nc_sig_q;
		a_exp  = a_is_p ? np_exp_q  : nc_exp_q;
		b_sign = a_is_p ? nc_sign_q : np_sign_q;
		b_sig  = a_is_p ? nc_sig_q  : np_sig_q;
		b_exp  = a_is_p ? nc_exp_q  : np_exp_q;
		b_zero = a_is_p ? nc_zero_q : np_zero_q;
		dif    = a_exp - b_exp;
		b_full = {b_sig, 27'd0};
		if (b_zero) begin
			b_shift  = 51'd0;
			b_sticky = 1'b0;
		end else if (dif > 11'sd50) begin
			b_shift  = 51'd0;
			b_sticky = |b_sig;
		end else begin
			b_shift  = b_full >> dif[5:0];
			b_sticky = |(b_full & ((51'd1 << dif[5:0]) - 51'd1));
		end
	end

	// Leading-one position and the weight of the kept LSB.
	logic [5:0]            s_top;
	logic signed [EW-1:0]  lsb_a, lsb_b;

	always_comb begin
		s_top = top52(s_q);
		lsb_a = $signed({5'd0, s_top}) - TOP_OFF;
		lsb_b = LOW_LSB - ea_q;
	end

	// Round to nearest even.
	logic [63:0]           sx, q0;
	logic [5:0]            sh;
	logic                  rbit, rsticky, rinc;
	logic [24:0]           q_n;
	logic signed [EW-1:0]  nlsb;

	always_comb begin
		sx      = {12'd0, s_q};
		nlsb    = -lsb_q;
		sh      = (lsb_q > 11'sd63) ? 6'd63 : lsb_q[5:0];
		q0      = sx >> sh;
		rbit    = 1'b0;
		rsticky = 1'b0;
		rinc    = 1'b0;
		if (lsb_q <= 11'sd0) begin
			q_n = 25'(s_q << nlsb[4:0]);
		end else begin
			rbit    = sx[sh - 6'd1];
			rsticky = |(sx & ((64'd1 << (sh - 6'd1)) - 64'd1));
			rinc    = rbit && (rsticky || q0[0]);
			q_n     = 25'(q0) + 25'(rinc);
		end
	end

	// Final packing.
	logic [23:0]           qq;
	logic signed [EW-1:0]  e2, bexp;

	always_comb begin
		if (q_q[24]) begin
			qq = q_q[24:1];
			e2 = eq_q + 11'sd1;
		end else begin
			qq = q_q[23:0];
			e2 = eq_q;
		end
		bexp = e2 + BIAS;
		if (spec_q) begin
			res = spec_val_q;
		end else if (zero_q) begin
			res = 32'd0;
		end else if (qq[23]) begin
			if (bexp >= EXP_MAX) res = {sgn_q, 8'hFF, 23'd0};
			else res = {sgn_q, bexp[7:0], qq[22:0]};
		end else begin
			res = {sgn_q, 8'd0, qq[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 32'd0;
		end else if (cmd.pack) begin
			acc_q <= cmd.clear ? 32'd0 : res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.norm) begin
			spec_q     <= n_spec;
			spec_val_q <= n_spec_val;
			np_sign_q  <= prod.sign;
			np_sig_q   <= p_nsig;
			np_exp_q   <= p_nexp;
			np_zero_q  <= p_zero;
			nc_sign_q  <= acc_q[31];
			nc_sig_q   <= c_nsig;
			nc_exp_q   <= c_nexp;
			nc_zero_q  <= c_zero;
		end
		if (cmd.align) begin
			aw_q  <= {a_sig, 27'd0};
			bw_q  <= b_shift | 51'(b_sticky);
			sub_q <= a_sign != b_sign;
			sgn_q <= a_sign;
			ea_q  <= a_exp;
		end
		if (cmd.add) begin
			s_q <= sub_q ? ({1'b0, aw_q} - {1'b0, bw_q}) : ({1'b0, aw_q} + {1'b0, bw_q});
		end
		if (cmd.lzc) begin
			zero_q <= (s_q == 52'd0);
			lsb_q  <= (lsb_a > lsb_b) ? lsb_a : lsb_b;
		end
		if (cmd.rnd) begin
			q_q  <= q_n;
			eq_q <= ea_q - GUARD + lsb_q;
		end
	end

endmodule

@@ sv/cldp_dp.sv @@
// Datapath: configuration, codebook and weight stores, index extraction, decode and the accumulating FMA.
module cldp_dp #(
	parameter int LUT_DEPTH    = 4096,
	parameter int WEIGHT_BYTES = 65536,
	parameter int MAX_ROW      = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cldp_pkg::dp_cmd_t         ctl,
	output cldp_pkg::dp_stat_t        stat,
	input  logic [1:0]                cmd,
	input  logic [11:0]               lut_slot,
	input  logic [15:0]               lut_word,
	input  logic [15:0]               byte_address,
	input  logic [7:0]                byte_data,
	input  logic [15:0]               column,
	input  logic [15:0]               activation,
	input  logic                      last,
	input  logic                      cfg_write,
	input  logic [1:0]                cfg_index,
	input  logic [cldp_pkg::CFG_W-1:0] cfg_data,
	output logic [31:0]               dot_value,
	output logic                      range_error
);

	localparam int LUT_AW = (LUT_DEPTH > 1) ? $clog2(LUT_DEPTH) : 1;
	localparam int WB_AW  = $clog2(WEIGHT_BYTES);
	localparam int POS_W  = $clog2(MAX_ROW);

	typedef struct packed {
		logic               sign;
		logic               nan;
		logic               inf;
		logic [10:0]        sig;
		logic signed [7:0]  exp;
	} val_t;

	function automatic val_t fp16_dec(input logic [15:0] h);
		val_t v;
		begin
			v      = '0;
			v.sign = h[15];
			if (h[14:10] == 5'd0) begin
				v.sig = {1'b0, h[9:0]};
				v.exp = -8'sd24;
			end else if (h[14:10] == 5'h1F) begin
				v.inf = (h[9:0] == 10'd0);
				v.nan = (h[9:0] != 10'd0);
			end else begin
				v.sig = {1'b1, h[9:0]};
				v.exp = $signed({3'b000, h[14:10]}) - 8'sd25;
			end
			return v;
		end
	endfunction

	function automatic val_t fp8_dec(input logic [7:0] x);
		val_t v;
		begin
			v      = '0;
			v.sign = x[7];
			if (x[6:3] == 4'd0) begin
				v.sig = 11'(x[2:0]);
				v.exp = -8'sd9;
			end else if (x[6:3] == 4'hF) begin
				v.sig = 11'd7;
				v.exp = 8'sd6;
			end else begin
				v.sig = 11'({1'b1, x[2:0]});
				v.exp = $signed({4'b0000, x[6:3]}) - 8'sd10;
			end
			return v;
		end
	endfunction

	logic [7:0]  wmem [WEIGHT_BYTES];
	logic [15:0] lmem [LUT_DEPTH];

	logic [3:0]                    ibits_q;
	logic                          fmt_q;
	logic [12:0]                   rowlen_q;
	logic [POS_W-1:0]              pos_q;
	logic                          rflag_q;
	logic [15:0]                   col_q, act_q;
	logic                          last_q;
	logic [cldp_pkg::WIDX_W-1:0]   widx_q;
	logic [cldp_pkg::BYTEPOS_W-1:0] bytepos_q;
	logic [2:0]                    shift_q;
	logic [1:0]                    need_q, rcnt_q, ridx_q;
	logic                          inr_q;
	logic [7:0]                    wbyte_q;
	logic [23:0]                   word_q;
	logic                          oob_q;
	logic [15:0]                   lut_rd_q;
	cldp_pkg::prod_t               prod_q;
	logic [31:0]                   dot_q;
	logic                          range_q;

	logic [3:0]                    bits_eff;
	logic [cldp_pkg::BITPOS_W-1:0] bitpos;
	logic [4:0]                    need_sum;
	logic [cldp_pkg::PTR_W-1:0]    rd_ptr;
	logic                          rd_inr, lut_wr_ok, byte_wr_ok;
	logic [11:0]                   mask, idx;
	logic                          idx_oob;
	logic [15:0]                   payload;
	val_t                          wv, av;
	logic                          a_zero, w_zero;
	cldp_pkg::prod_t               prod_n;
	cldp_pkg::fma_cmd_t            fcmd;
	logic [31:0]                   fma_res;

	always_comb begin
		bits_eff   = (ibits_q > 4'd12) ? 4'd12 : ibits_q;
		bitpos     = cldp_pkg::BITPOS_W'(widx_q) * cldp_pkg::BITPOS_W'(bits_eff);
		need_sum   = (5'(bitpos[2:0]) + 5'(bits_eff) + 5'd7) >> 3;
		rd_ptr     = cldp_pkg::PTR_W'(bytepos_q) + cldp_pkg::PTR_W'(rcnt_q);
		rd_inr     = rd_ptr < cldp_pkg::PTR_W'(WEIGHT_BYTES);
		lut_wr_ok  = {1'b0, lut_slot} < 13'(LUT_DEPTH);
		byte_wr_ok = cldp_pkg::PTR_W'(byte_address) < cldp_pkg::PTR_W'(WEIGHT_BYTES);
		for (int i = 0; i < 12; i++) mask[i] = (4'(i) < bits_eff);
		idx        = 12'(word_q >> shift_q) & mask;
		idx_oob    = {1'b0, idx} >= 13'(LUT_DEPTH);
		payload    = oob_q ? 16'd0 : lut_rd_q;
		av         = fp16_dec(act_q);
		wv         = fmt_q ? fp16_dec(payload) : fp8_dec(payload[7:0]);
		a_zero     = !av.inf && !av.nan && (av.sig == 11'd0);
		w_zero     = !wv.inf && !wv.nan && (wv.sig == 11'd0);
		prod_n.sign = av.sign ^ wv.sign;
		prod_n.nan  = av.nan || wv.nan || (av.inf && w_zero) || (wv.inf && a_zero);
		prod_n.inf  = (av.inf || wv.inf) && !prod_n.nan;
		prod_n.sig  = (av.inf || wv.inf || av.nan || wv.nan) ? 22'd0 :
			22'(av.sig) * 22'(wv.sig);
		prod_n.exp  = av.exp + wv.exp;
	end

	assign stat.in_act = (cmd == cldp_pkg::CMD_ACT);
	assign stat.last   = last_q;

	assign fcmd.norm  = ctl.norm;
	assign fcmd.align = ctl.align;
	assign fcmd.add   = ctl.add;
	assign fcmd.lzc   = ctl.lzc;
	assign fcmd.rnd   = ctl.rnd;
	assign fcmd.pack  = ctl.pack;
	assign fcmd.clear = last_q;

	cldp_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fcmd),
		.prod   (prod_q),
		.res    (fma_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ibits_q  <= 4'd4;
			fmt_q    <= 1'b0;
			rowlen_q <= 13'd4096;
			pos_q    <= '0;
			rflag_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					cldp_pkg::CFG_INDEX_BITS: ibits_q  <= cfg_data[3:0];
					cldp_pkg::CFG_FORMAT:     fmt_q    <= cfg_data[0];
					cldp_pkg::CFG_ROW_LENGTH: rowlen_q <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (ctl.rd_take && !inr_q && (ridx_q < need_q)) rflag_q <= 1'b1;
			if (ctl.pack) begin
				if (last_q) begin
					pos_q   <= '0;
					rflag_q <= 1'b0;
				end else if (pos_q != POS_W'(MAX_ROW - 1)) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && (cmd == cldp_pkg::CMD_LUT) && lut_wr_ok)
			lmem[LUT_AW'(lut_slot)] <= lut_word;
		if (ctl.lut && !idx_oob)
			lut_rd_q <= lmem[LUT_AW'(idx)];
		if (ctl.load && (cmd == cldp_pkg::CMD_BYTE) && byte_wr_ok)
			wmem[WB_AW'(byte_address)] <= byte_data;
		if (ctl.rd_issue && rd_inr)
			wbyte_q <= wmem[WB_AW'(rd_ptr)];
	end

	always_ff @(posedge clk) begin
		if (ctl.load && (cmd == cldp_pkg::CMD_ACT)) begin
			col_q  <= column;
			act_q  <= activation;
			last_q <= last;
		end
		if (ctl.addr)
			widx_q <= cldp_pkg::WIDX_W'(col_q) * cldp_pkg::WIDX_W'(rowlen_q) +
				cldp_pkg::WIDX_W'(pos_q);
		if (ctl.bitp) begin
			bytepos_q <= bitpos[cldp_pkg::BITPOS_W-1:3];
			shift_q   <= bitpos[2:0];
			need_q    <= (bits_eff == 4'd0) ? 2'd0 : need_sum[1:0];
			rcnt_q    <= 2'd0;
		end
		if (ctl.rd_issue) begin
			inr_q  <= rd_inr;
			ridx_q <= rcnt_q;
			rcnt_q <= rcnt_q + 2'd1;
		end
		if (ctl.rd_take)
			word_q <= {inr_q ? wbyte_q : 8'h00, word_q[23:8]};
		if (ctl.lut)
			oob_q <= idx_oob;
		if (ctl.dec)
			prod_q <= prod_n;
		if (ctl.pack && last_q) begin
			dot_q   <= fma_res;
			range_q <= rflag_q;
		end
	end

	assign dot_value   = dot_q;
	assign range_error = range_q;

endmodule

@@ sv/cldp_ctrl.sv @@
// Controller state machine sequencing each activation through the datapath.
module cldp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  cldp_pkg::dp_stat_t  stat,
	output cldp_pkg::dp_cmd_t   ctl
);

	typedef enum logic [3:0] {
		S_IDLE, S_ADDR, S_BITP, S_RD0, S_RD1, S_RD2, S_RD3, S_LUT,
		S_DEC, S_NORM, S_ALIGN, S_ADD, S_LZC, S_RND, S_PACK
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   pack_go;

	assign pack_go   = !(stat.last && out_valid_q && !out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE:  ctl.load = in_valid;
			S_ADDR:  ctl.addr = 1'b1;
			S_BITP:  ctl.bitp = 1'b1;
			S_RD0:   ctl.rd_issue = 1'b1;
			S_RD1, S_RD2: begin
				ctl.rd_issue = 1'b1;
				ctl.rd_take  = 1'b1;
			end
			S_RD3:   ctl.rd_take = 1'b1;
			S_LUT:   ctl.lut = 1'b1;
			S_DEC:   ctl.dec = 1'b1;
			S_NORM:  ctl.norm = 1'b1;
			S_ALIGN: ctl.align = 1'b1;
			S_ADD:   ctl.add = 1'b1;
			S_LZC:   ctl.lzc = 1'b1;
			S_RND:   ctl.rnd = 1'b1;
			S_PACK:  ctl.pack = pack_go;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_PACK) && pack_go && stat.last) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:  if (in_valid && stat.in_act) state_q <= S_ADDR;
				S_ADDR:  state_q <= S_BITP;
				S_BITP:  state_q <= S_RD0;
				S_RD0:   state_q <= S_RD1;
				S_RD1:   state_q <= S_RD2;
				S_RD2:   state_q <= S_RD3;
				S_RD3:   state_q <= S_LUT;
				S_LUT:   state_q <= S_DEC;
				S_DEC:   state_q <= S_NORM;
				S_NORM:  state_q <= S_ALIGN;
				S_ALIGN: state_q <= S_ADD;
				S_ADD:   state_q <= S_LZC;
				S_LZC:   state_q <= S_RND;
				S_RND:   state_q <= S_PACK;
				S_PACK: begin
					if (pack_go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/codebook_lut_dot_product.sv @@
// Top level of the codebook dot-product block.
// Codebook and weight-byte writes are taken one per cycle while the block is
// idle. An activation is taken, then the block is busy and takes no further
// item until it has done the address arithmetic, the three byte reads through
// the single port of the weight store, the codebook read, the decode with the
// product, and the fused add into the accumulator. A finished sum waits in the
// output register while further writes and activations are taken; only the
// next sum waits for its transfer.
module codebook_lut_dot_product #(
	parameter int LUT_DEPTH    = 4096,
	parameter int WEIGHT_BYTES = 65536,
	parameter int MAX_ROW      = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 cmd,
	input  logic [11:0]                lut_slot,
	input  logic [15:0]                lut_word,
	input  logic [15:0]                byte_address,
	input  logic [7:0]                 byte_data,
	input  logic [15:0]                column,
	input  logic [15:0]                activation,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [31:0]                dot_value,
	output logic                       range_error,
	input  logic                       cfg_write,
	input  logic [1:0]                 cfg_index,
	input  logic [cldp_pkg::CFG_W-1:0] cfg_data
);

	cldp_pkg::dp_cmd_t  ctl;
	cldp_pkg::dp_stat_t stat;

	cldp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	cldp_dp #(
		.LUT_DEPTH    (LUT_DEPTH),
		.WEIGHT_BYTES (WEIGHT_BYTES),
		.MAX_ROW      (MAX_ROW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cmd          (cmd),
		.lut_slot     (lut_slot),
		.lut_word     (lut_word),
		.byte_address (byte_address),
		.byte_data    (byte_data),
		.column       (column),
		.activation   (activation),
		.last         (last),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.dot_value    (dot_value),
		.range_error  (range_error)
	);

endmodule

@@ sv/cldp_checker.sv @@
// Port-level checker for the codebook dot-product block, bound to the top level.
`include "assert_macros.svh"

module cldp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  cmd,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] dot_value,
	input logic        range_error
);

	// A write or unused command is finished in its own transfer cycle.
	`CLDP_ASSERT_NEXT(a_write_keeps_ready, clk, arst_n, in_valid && in_ready && (cmd != cldp_pkg::CMD_ACT), in_ready)

	// An activation occupies the sequencer after its transfer.
	`CLDP_ASSERT_NEXT(a_act_busy, clk, arst_n, in_valid && in_ready && (cmd == cldp_pkg::CMD_ACT), !in_ready)

	// A stalled result is held.
	`CLDP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(dot_value) && $stable(range_error))

	// Any NaN sum leaves in canonical form.
	`CLDP_ASSERT_IMPL(a_nan_canon, clk, arst_n, out_valid && (dot_value[30:23] == 8'hFF) && (dot_value[22:0] != 23'd0), dot_value == cldp_pkg::CANON_NAN)

endmodule

bind codebook_lut_dot_product cldp_checker u_cldp_checker (.*);

@@ tb/sv/tb_codebook_lut_dot_product.sv @@
// Self-checking testbench of the codebook dot-product block with a bit-exact FP32 predictor.
`timescale 1ns / 1ps

module tb_codebook_lut_dot_product;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int NOISE_LIMIT = 2000;
	localparam int SETTLE = 40;

	typedef struct {
		logic [1:0]  cmd;
		logic [11:0] slot;
		logic [15:0] word;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [15:0] col;
		logic [15:0] act;
		logic        last;
	} item_t;

	typedef struct {
		logic [31:0] dot;
		logic        err;
	} sum_t;

	typedef struct {
		item_t       it;
		bit          typed;
		logic [31:0] dot;
		logic        err;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = '0;
	logic [11:0] lut_slot = '0;
	logic [15:0] lut_word = '0;
	logic [15:0] byte_address = '0;
	logic [7:0] byte_data = '0;
	logic [15:0] column = '0;
	logic [15:0] activation = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] dot_value;
	logic range_error;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [cldp_pkg::CFG_W-1:0] cfg_data = '0;

	codebook_lut_dot_product dut (.*);

	always #5 clk = ~clk;

	// Predictor state.
	logic [15:0] cb_mem [4096];
	bit cb_known [4096];
	logic [7:0] ws_mem [65536];
	bit ws_known [65536];
	logic [31:0] acc_bits = '0;
	int unsigned pos = 0;
	logic sticky_overrun = 1'b0;
	int unsigned ib_reg = 4;
	logic fmt_reg = 1'b0;
	int unsigned rowlen_reg = 4096;

	sum_t pending_sums [$];
	int mismatches = 0;
	int sent = 0;
	int idle_in = 30;
	int idle_out = 88;
	int quiet = 0;
	int total_items = 1600;

	function automatic logic [31:0] to_single(logic [63:0] d);
		logic s;
		int e, fe, sh;
		logic [63:0] sig, kept, rem, halfv;
		s = d[63];
		e = int'(d[62:52]);
		if (e == 2047)
			return {s, 8'hFF, (d[51:0] != 0) ? 23'h400000 : 23'h0};
		if (e == 0)
			return {s, 31'h0};
		fe = e - 1023 + 127;
		if (fe >= 255)
			return {s, 8'hFF, 23'h0};
		sig = {11'h0, 1'b1, d[51:0]};
		sh = (fe >= 1) ? 29 : 30 - fe;
		if (sh > 54)
			return {s, 31'h0};
		kept = sig >> sh;
		rem = sig & ((64'd1 << sh) - 1);
		halfv = 64'd1 << (sh - 1);
		if (rem > halfv || (rem == halfv && kept[0]))
			kept = kept + 1;
		if (fe < 1)
			return {s, kept[30:0]};
		if (kept[24]) begin
			kept = kept >> 1;
			fe = fe + 1;
		end
		if (fe >= 255)
			return {s, 8'hFF, 23'h0};
		return {s, fe[7:0], kept[22:0]};
	endfunction

	function automatic real to_double(logic [31:0] f);
		int e;
		real r;
		e = int'(f[30:23]);
		if (e == 255)
			return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'h0});
		if (e == 0) begin
			r = real'(f[22:0]) * (2.0 ** (-149));
			return f[31] ? -r : r;
		end
		return $bitstoreal({f[31], 11'(e + 896), f[22:0], 29'h0});
	endfunction

	function automatic logic [31:0] half_to_single(logic [15:0] h);
		logic [4:0] e;
		logic [9:0] m;
		e = h[14:10];
		m = h[9:0];
		if (e == 0)
			return to_single($realtobits(real'(m) * (2.0 ** (-24)))) | {h[15], 31'h0};
		if (e == 31)
			return {h[15], 8'hFF, m, 13'h0} | ((m != 0) ? 32'h0040_0000 : 32'h0);
		return {h[15], 8'(e + 112), m, 13'h0};
	endfunction

	function automatic logic [31:0] fp8_to_single(logic [7:0] x);
		logic [3:0] e;
		logic [2:0] m;
		logic [31:0] mag;
		e = x[6:3];
		m = x[2:0];
		if (e == 0)
			mag = to_single($realtobits(real'(m) * (2.0 ** (-9))));
		else if (e == 4'hF)
			mag = 32'h43E0_0000;
		else
			mag = {1'b0, 8'(e + 120), m, 20'h0};
		return mag | {x[7], 31'h0};
	endfunction

	function automatic logic [31:0] fused_mac(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		real p, cd, s, bv, rest;
		logic [63:0] sb;
		p = to_double(a) * to_double(b);
		cd = to_double(c);
		s = p + cd;
		sb = $realtobits(s);
		if (sb[62:52] != 11'h7FF) begin
			bv = s - p;
			rest = (p - (s - bv)) + (cd - bv);
			if (rest != 0.0 && !sb[0]) begin
				if ((rest > 0.0) == (s > 0.0))
					sb = sb + 1;
				else
					sb = sb - 1;
			end
		end
		return to_single(sb);
	endfunction

	function automatic int unsigned eff_bits();
		return (ib_reg > 12) ? 12 : ib_reg;
	endfunction

	function automatic longint unsigned first_byte(logic [15:0] col);
		longint unsigned widx;
		widx = longint'(col) * rowlen_reg + pos;
		return (widx * eff_bits()) >> 3;
	endfunction

	// Gathers the packed index of the next activation, and whether a needed byte overran.
	function automatic logic [11:0] packed_index(logic [15:0] col, output logic overrun);
		longint unsigned widx, bitpos, bp, a;
		int unsigned bits, sh, need;
		logic [31:0] word;
		bits = eff_bits();
		widx = longint'(col) * rowlen_reg + pos;
		bitpos = widx * bits;
		bp = bitpos >> 3;
		sh = 32'(bitpos & 7);
		need = bits ? (sh + bits + 7) >> 3 : 0;
		word = '0;
		overrun = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a = bp + i;
			if (a < 65536)
				word = word | (32'(ws_mem[a]) << (8 * i));
			else if (i < need)
				overrun = 1'b1;
		end
		return 12'((word >> sh) & ((32'd1 << bits) - 1));
	endfunction

	function automatic bit accumulate(item_t it, output sum_t res);
		logic ov;
		logic [11:0] idx;
		logic [31:0] w, r;
		case (it.cmd)
			cldp_pkg::CMD_LUT: begin
				cb_mem[it.slot] = it.word;
				cb_known[it.slot] = 1'b1;
				return 0;
			end
			cldp_pkg::CMD_BYTE: begin
				ws_mem[it.addr] = it.data;
				ws_known[it.addr] = 1'b1;
				return 0;
			end
			cldp_pkg::CMD_ACT: ;
			default: return 0;
		endcase
		idx = packed_index(it.col, ov);
		sticky_overrun = sticky_overrun | ov;
		w = fmt_reg ? half_to_single(cb_mem[idx]) : fp8_to_single(cb_mem[idx][7:0]);
		acc_bits = fused_mac(half_to_single(it.act), w, acc_bits);
		if (pos + 1 < 4096)
			pos++;
		if (!it.last)
			return 0;
		r = acc_bits;
		if (r[30:23] == 8'hFF && r[22:0] != 0)
			r = cldp_pkg::CANON_NAN;
		res.dot = r;
		res.err = sticky_overrun;
		acc_bits = '0;
		pos = 0;
		sticky_overrun = 1'b0;
		return 1;
	endfunction

	task automatic transfer(item_t it, bit typed = 0, logic [31:0] tdot = '0, logic terr = 0);
		sum_t res;
		@(negedge clk);
		while ($urandom_range(99) < idle_in) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		lut_slot <= it.slot;
		lut_word <= it.word;
		byte_address <= it.addr;
		byte_data <= it.data;
		column <= it.col;
		activation <= it.act;
		last <= it.last;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (accumulate(it, res)) begin
			if (typed) begin
				res.dot = tdot;
				res.err = terr;
			end
			pending_sums = {pending_sums, res};
		end
		if (sent < total_items / 3) begin
			idle_in = 30;
			idle_out = 88;
		end else if (sent < 2 * total_items / 3) begin
			idle_in = 88;
			idle_out = 30;
		end else begin
			idle_in = 0;
			idle_out = 0;
		end
	endtask

	// Writes every store entry that the activation will read and that is still unwritten, before sending it.
	task automatic send(item_t it, bit typed = 0, logic [31:0] tdot = '0, logic terr = 0);
		item_t fill;
		longint unsigned bp;
		logic ov;
		logic [11:0] idx;
		if (it.cmd == cldp_pkg::CMD_ACT) begin
			bp = first_byte(it.col);
			for (int i = 0; i < 3; i++) begin
				if (bp + i < 65536 && !ws_known[bp + i]) begin
					fill = '{cldp_pkg::CMD_BYTE, 12'($urandom), 16'($urandom), 16'(bp + i),
						8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)};
					transfer(fill);
				end
			end
			idx = packed_index(it.col, ov);
			if (!cb_known[idx]) begin
				fill = '{cldp_pkg::CMD_LUT, idx, 16'($urandom), 16'($urandom), 8'($urandom),
					16'($urandom), 16'($urandom), 1'($urandom)};
				transfer(fill);
			end
		end
		transfer(it, typed, tdot, terr);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(int unsigned ib, logic fmt, int unsigned rl);
		drain();
		ib_reg = ib & 4'hF;
		fmt_reg = fmt;
		rowlen_reg = rl & 13'h1FFF;
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= cldp_pkg::CFG_INDEX_BITS;
		cfg_data <= cldp_pkg::CFG_W'(ib);
		@(negedge clk);
		cfg_index <= cldp_pkg::CFG_FORMAT;
		cfg_data <= cldp_pkg::CFG_W'(fmt);
		@(negedge clk);
		cfg_index <= cldp_pkg::CFG_ROW_LENGTH;
		cfg_data <= cldp_pkg::CFG_W'(rl);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [15:0] rand_half();
		if ($urandom_range(19) == 0)
			return 16'($urandom);
		return {1'($urandom), 5'($urandom_range(8, 21)), 10'($urandom)};
	endfunction

	function automatic logic [15:0] rand_column();
		int k;
		k = $urandom_range(9);
		if (k < 7)
			return 16'($urandom_range(15));
		if (k < 9)
			return 16'($urandom);
		return 16'(65535 - $urandom_range(3));
	endfunction

	// Sends random traffic until the count of transfers reaches the given mark.
	task automatic random_traffic(int upto);
		item_t it;
		int len, k;
		logic [15:0] col;
		while (sent < upto) begin
			k = $urandom_range(9);
			if (k == 0) begin
				it = '{2'($urandom_range(cldp_pkg::CMD_LUT, CMD_UNUSED)), 12'($urandom),
					16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
					16'($urandom), 1'($urandom)};
				if (it.cmd == cldp_pkg::CMD_ACT)
					it.cmd = CMD_UNUSED;
				send(it);
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
				col = rand_column();
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(7) == 0)
						col = rand_column();
					it = '{cldp_pkg::CMD_ACT, 12'($urandom), 16'($urandom), 16'($urandom),
						8'($urandom), col, rand_half(), i == len - 1};
					send(it);
				end
			end
		end
	endtask

	task automatic report(string what, logic [31:0] want_dot, logic want_err,
			logic [31:0] got_dot, logic got_err);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected %h/%b, got %h/%b", what, want_dot, want_err, got_dot, got_err);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= idle_out);

	always @(posedge clk) begin
		sum_t want;
		if (out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				report("unexpected result", '0, 1'b0, dot_value, range_error);
			end else begin
				want = pending_sums.pop_front();
				if (dot_value !== want.dot || range_error !== want.err)
					report("result mismatch", want.dot, want.err, dot_value, range_error);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= NOISE_LIMIT) begin
			$display("[codebook_lut_dot_product] ERROR");
			$finish;
		end
	end

	row_t rows [18] = '{
		'{'{cldp_pkg::CMD_LUT, 12'd0, 16'h0038, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_LUT, 12'd15, 16'h007F, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_LUT, 12'd1, 16'hFFFF, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_LUT, 12'd4095, 16'h7C00, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_BYTE, 12'd0, 16'd0, 16'd0, 8'hF0, 16'd0, 16'd0, 1'b0},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_BYTE, 12'd0, 16'd0, 16'd1, 8'h10, 16'd0, 16'd0, 1'b0},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_BYTE, 12'd0, 16'd0, 16'd2, 8'hFF, 16'd0, 16'd0, 1'b0},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_BYTE, 12'hFFF, 16'hFFFF, 16'hFFFF, 8'h00, 16'hFFFF, 16'hFFFF, 1'b1},
			0, 32'h0, 1'b0},
		'{'{CMD_UNUSED, 12'hFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_ACT, 12'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'h3C00, 1'b1},
			1, 32'h3F80_0000, 1'b0},
		'{'{cldp_pkg::CMD_ACT, 12'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'h3C00, 1'b0},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_ACT, 12'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'h4000, 1'b1},
			1, 32'h4460_4000, 1'b0},
		'{'{cldp_pkg::CMD_ACT, 12'd0, 16'd0, 16'd0, 8'd0, 16'hFFFF, 16'h3C00, 1'b1},
			1, 32'h3F80_0000, 1'b1},
		'{'{cldp_pkg::CMD_ACT, 12'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'hFFFF, 1'b1},
			1, cldp_pkg::CANON_NAN, 1'b0},
		'{'{cldp_pkg::CMD_ACT, 12'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'h7C00, 1'b1},
			1, 32'h7F80_0000, 1'b0},
		'{'{cldp_pkg::CMD_ACT, 12'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'h0001, 1'b0},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_ACT, 12'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'hFBFF, 1'b0},
			0, 32'h0, 1'b0},
		'{'{cldp_pkg::CMD_ACT, 12'd0, 16'd0, 16'd0, 8'd0, 16'd3, 16'h8000, 1'b1},
			0, 32'h0, 1'b0}
	};

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send(rows[i].it, rows[i].typed, rows[i].dot, rows[i].err);
		set_regs(0, 1'b1, 0);
		foreach (rows[i])
			if (rows[i].it.cmd == cldp_pkg::CMD_ACT)
				send(rows[i].it);

		set_regs(1, 1'b1, 1);
		random_traffic(250);
		set_regs(12, 1'b0, 4096);
		random_traffic(480);
		set_regs(15, 1'b1, 8191);
		random_traffic(680);
		set_regs(4, 1'b1, 16);
		random_traffic(900);
		set_regs($urandom_range(2, 11), 1'b0, $urandom_range(1, 40));
		random_traffic(1120);
		set_regs($urandom_range(1, 15), 1'($urandom), $urandom_range(0, 8191));
		random_traffic(1340);
		set_regs(8, 1'b0, 3);
		random_traffic(1480);
		set_regs(1, 1'b0, 1);
		random_traffic(total_items);

		drain();
		if (mismatches == 0 && pending_sums.size() == 0)
			$display("[codebook_lut_dot_product] OK");
		else
			$display("[codebook_lut_dot_product] ERROR");
		$finish;
	end

endmodule
